// ===== src/nmit_pkg.sv =====
`timescale 1ns / 1ps
package nmit_pkg;

  localparam int ELEM_W = 24;
  localparam int COF_W  = 2 * ELEM_W + 1;
  localparam int DET_W  = 3 * ELEM_W + 2;
  localparam int LAT    = ELEM_W + 8;

  typedef logic signed [ELEM_W-1:0] elem_t;

  typedef struct packed {
    elem_t in_c0r0;
    elem_t in_c0r1;
    elem_t in_c0r2;
    elem_t in_c1r0;
    elem_t in_c1r1;
    elem_t in_c1r2;
    elem_t in_c2r0;
    elem_t in_c2r1;
    elem_t in_c2r2;
  } in_t;

  typedef struct packed {
    elem_t out_c0r0;
    elem_t out_c0r1;
    elem_t out_c0r2;
    elem_t out_c1r0;
    elem_t out_c1r1;
    elem_t out_c1r2;
    elem_t out_c2r0;
    elem_t out_c2r1;
    elem_t out_c2r2;
    logic  singular;
  } out_t;

  // cofactors and determinant handed from front to back
  typedef struct packed {
    logic [8:0][COF_W-1:0] cof;
    logic [DET_W-1:0]      det;
  } item_t;

  // cofactor i = m[CA]*m[CB] - m[CC]*m[CD]
  localparam logic [3:0] CA [9] = '{4'd4, 4'd5, 4'd3, 4'd2, 4'd0, 4'd1, 4'd1, 4'd2, 4'd0};
  localparam logic [3:0] CB [9] = '{4'd8, 4'd6, 4'd7, 4'd7, 4'd8, 4'd6, 4'd5, 4'd3, 4'd4};
  localparam logic [3:0] CC [9] = '{4'd5, 4'd3, 4'd4, 4'd1, 4'd2, 4'd0, 4'd2, 4'd0, 4'd1};
  localparam logic [3:0] CD [9] = '{4'd7, 4'd8, 4'd6, 4'd8, 4'd6, 4'd7, 4'd4, 4'd5, 4'd3};

endpackage

// ===== src/nmit_front.sv =====
`timescale 1ns / 1ps
module nmit_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  nmit_pkg::in_t req,
  output logic          item_valid,
  output nmit_pkg::item_t item
);
  import nmit_pkg::*;

  typedef logic signed [2*ELEM_W-1:0] prod_t;
  typedef logic signed [COF_W-1:0]    cof_t;
  typedef logic signed [2*ELEM_W:0]   pp_t;
  typedef logic signed [DET_W-1:0]    sdet_t;

  elem_t m [9];
  prod_t pa_next [9];
  prod_t pb_next [9];
  prod_t pa [9];
  prod_t pb [9];
  elem_t m1 [3];
  elem_t m2 [3];
  cof_t  cof [9];
  cof_t  cof3 [9];
  pp_t   pl [3];
  pp_t   ph [3];
  logic  v1, v2, v3;
  sdet_t det_next;

  always_comb begin
    m[0] = req.in_c0r0; m[1] = req.in_c0r1; m[2] = req.in_c0r2;
    m[3] = req.in_c1r0; m[4] = req.in_c1r1; m[5] = req.in_c1r2;
    m[6] = req.in_c2r0; m[7] = req.in_c2r1; m[8] = req.in_c2r2;
    for (int i = 0; i < 9; i++) begin
      pa_next[i] = prod_t'(m[CA[i]]) * prod_t'(m[CB[i]]);
      pb_next[i] = prod_t'(m[CC[i]]) * prod_t'(m[CD[i]]);
    end
  end

  always_comb begin
    det_next = '0;
    for (int i = 0; i < 3; i++) begin
      det_next = det_next + (sdet_t'(ph[i]) <<< ELEM_W) + sdet_t'(pl[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      item_valid <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      item_valid <= v3;
    end
    for (int i = 0; i < 9; i++) begin
      pa[i]   <= pa_next[i];
      pb[i]   <= pb_next[i];
      cof[i]  <= cof_t'(pa[i]) - cof_t'(pb[i]);
      cof3[i] <= cof[i];
      item.cof[i] <= cof3[i];
    end
    for (int i = 0; i < 3; i++) begin
      m1[i] <= m[i];
      m2[i] <= m1[i];
      pl[i] <= pp_t'(m2[i]) * pp_t'($signed({1'b0, cof[i][ELEM_W-1:0]}));
      ph[i] <= pp_t'(m2[i]) * pp_t'($signed(cof[i][COF_W-1:ELEM_W]));
    end
    item.det <= det_next;
  end

endmodule

// ===== src/nmit_queue.sv =====
`timescale 1ns / 1ps
module nmit_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  nmit_pkg::item_t push_data,
  output logic            pop,
  output nmit_pkg::item_t pop_data,
  output logic            full
);
  import nmit_pkg::*;

  item_t      mem [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign pop      = (cnt != 2'd0);
  assign full     = (cnt == 2'd2);
  assign pop_data = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_data;
    end
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== src/nmit_back.sv =====
`timescale 1ns / 1ps
module nmit_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  input  nmit_pkg::item_t item,
  output logic            done,
  output nmit_pkg::out_t  result
);
  import nmit_pkg::*;

  localparam int RW = 4 * ELEM_W + 2 * FRAC_BITS + 2;
  localparam logic [ELEM_W-1:0] LIM_POS = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic [ELEM_W-1:0] LIM_NEG = {1'b1, {(ELEM_W-1){1'b0}}};

  typedef struct packed {
    logic                   v;
    logic                   sing;
    logic [8:0]             neg;
    logic [8:0]             ovf;
    logic [RW-1:0]          dd;
    logic [8:0][RW-1:0]     r;
    logic [8:0][ELEM_W-1:0] q;
  } dstage_t;

  dstage_t b0, b0_next;
  dstage_t st [ELEM_W+1];
  dstage_t st0_next;

  logic [COF_W-1:0] ac;
  logic [DET_W-1:0] ad;

  always_comb begin
    b0_next = '0;
    b0_next.v = item_valid;
    b0_next.sing = (item.det == '0);
    ad = item.det[DET_W-1] ? (~item.det + 1'b1) : item.det;
    b0_next.dd = RW'(ad) << 1;
    ac = '0;
    for (int i = 0; i < 9; i++) begin
      ac = item.cof[i][COF_W-1] ? (~item.cof[i] + 1'b1) : item.cof[i];
      b0_next.neg[i] = item.cof[i][COF_W-1] ^ item.det[DET_W-1];
      b0_next.r[i] = (RW'(ac) << (2 * FRAC_BITS + 1)) + RW'(ad);
    end
  end

  always_comb begin
    st0_next = b0;
    for (int i = 0; i < 9; i++) begin
      st0_next.ovf[i] = (b0.r[i] >= (b0.dd << ELEM_W));
      st0_next.q[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b0 <= '0;
      st[0] <= '0;
    end else begin
      b0 <= b0_next;
      st[0] <= st0_next;
    end
  end

  for (genvar s = 0; s < ELEM_W; s++) begin : g_div
    logic [RW-1:0] sh;
    dstage_t       nx;
    assign sh = st[s].dd << (ELEM_W - 1 - s);
    always_comb begin
      nx = st[s];
      for (int i = 0; i < 9; i++) begin
        if (st[s].r[i] >= sh) begin
          nx.r[i] = st[s].r[i] - sh;
          nx.q[i] = {st[s].q[i][ELEM_W-2:0], 1'b1};
        end else begin
          nx.q[i] = {st[s].q[i][ELEM_W-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        st[s+1] <= '0;
      end else begin
        st[s+1] <= nx;
      end
    end
  end

  dstage_t                fin;
  logic [ELEM_W-1:0]      lim, mag;
  logic [8:0][ELEM_W-1:0] val;
  out_t                   res_next;

  assign fin = st[ELEM_W];

  always_comb begin
    lim = '0;
    mag = '0;
    for (int i = 0; i < 9; i++) begin
      lim = fin.neg[i] ? LIM_NEG : LIM_POS;
      mag = (fin.ovf[i] || fin.q[i] > lim) ? lim : fin.q[i];
      val[i] = fin.sing ? '0 : (fin.neg[i] ? (~mag + 1'b1) : mag);
    end
    res_next.out_c0r0 = val[0];
    res_next.out_c0r1 = val[1];
    res_next.out_c0r2 = val[2];
    res_next.out_c1r0 = val[3];
    res_next.out_c1r1 = val[4];
    res_next.out_c1r2 = val[5];
    res_next.out_c2r0 = val[6];
    res_next.out_c2r1 = val[7];
    res_next.out_c2r2 = val[8];
    res_next.singular = fin.sing;
  end

  always_ff @(posedge clk) begin
    result <= res_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin.v;
    end
  end

endmodule

// ===== src/normal_matrix_inverse_transpose_unit.sv =====
`timescale 1ns / 1ps
// 3x3 inverse-transpose for normal matrices, signed fixed point, column-major.
// input: drive req with the nine elements and raise start; the request is
//   taken on a rising edge where start is high and busy is low.
// output: done is high for one cycle per result, with result valid in that cycle;
//   the receiver cannot stall, so results are never held back.
// throughput: one request per cycle.
// the front computes cofactors and the determinant in four stages, a two-entry
//   queue decouples it from the back, which runs a pipelined restoring divider
//   with one quotient bit per stage for all nine elements, then saturates.
// a zero determinant gives singular high and all elements zero.
// reset (rst, synchronous) drops every request in flight; no result follows.
// busy only rises if the queue is full, which a draining back never allows.
module normal_matrix_inverse_transpose_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  nmit_pkg::in_t  req,
  output logic           done,
  output nmit_pkg::out_t result
);
  import nmit_pkg::*;

  logic  accept, item_valid, pop, full;
  item_t item, pop_data;

  assign accept = start && !busy;
  assign busy   = full;

  nmit_front u_front (
    .clk(clk), .rst(rst), .accept(accept), .req(req),
    .item_valid(item_valid), .item(item)
  );

  nmit_queue u_queue (
    .clk(clk), .rst(rst), .push(item_valid), .push_data(item),
    .pop(pop), .pop_data(pop_data), .full(full)
  );

  nmit_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .item_valid(pop), .item(pop_data),
    .done(done), .result(result)
  );

endmodule

// ===== src/nmit_checker.sv =====
`timescale 1ns / 1ps
module nmit_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input nmit_pkg::in_t  req,
  input logic           done,
  input nmit_pkg::out_t result
);
  import nmit_pkg::*;

  a_reset_clears: assert property (@(posedge clk) rst |=> !done)
    else $error("done after reset");

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.singular |-> result.out_c0r0 == '0 && result.out_c1r1 == '0 &&
      result.out_c2r2 == '0 && result.out_c0r1 == '0 && result.out_c2r0 == '0)
    else $error("singular result not zero");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LAT done)
    else $error("missing result");

endmodule

bind normal_matrix_inverse_transpose_unit nmit_checker u_nmit_checker (.*);
